// ===== hdl/go_to_goal_heading_controller_defines.svh =====
// Assertion macros for the go-to-goal heading controller.
// They sample on clk and are disabled while rst is high.
`ifndef GO_TO_GOAL_HEADING_CONTROLLER_DEFINES_SVH
`define GO_TO_GOAL_HEADING_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define GGH_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GGH_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ggh_pkg.sv =====
`timescale 1ns / 1ps

package ggh_pkg;

  localparam int POS_W      = 24;
  localparam int HDG_W      = 16;
  localparam int LIN_W      = 13;
  localparam int ANG_CMD_W  = 14;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int YAW_TOL_W  = 15;
  localparam int POS_TOL_W  = 23;
  localparam int RATE_W     = 13;

  localparam int DIFF_W = POS_W + 1;
  localparam int XY_W   = 36;
  localparam int Z_W    = 25;
  localparam int BRG_W  = Z_W - 7;
  localparam int ERR_W  = 20;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SQ_W   = PROD_W - 1;
  localparam int D2_W   = PROD_W;

  localparam int MAX_ITER   = 24;
  localparam int ATAN_IDX_W = $clog2(MAX_ITER);

  localparam logic signed [Z_W-1:0]   Q20_PI     = 25'sd3294199;
  localparam logic signed [Z_W-1:0]   Z_ROUND    = 25'sd64;
  localparam logic signed [ERR_W-1:0] ERR_PI     = 20'sd25736;
  localparam logic signed [ERR_W-1:0] ERR_NEG_PI = -20'sd25736;
  localparam logic signed [ERR_W-1:0] ERR_TWO_PI = 20'sd51472;

  typedef enum logic [MODE_W-1:0] {
    MODE_HEADING  = 2'd0,
    MODE_STRAIGHT = 2'd1,
    MODE_DONE     = 2'd2
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_TOL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_TOL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_RATE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SPEED = 3'd5;

  localparam logic [YAW_TOL_W-1:0] YAW_TOL_RESET = 15'd286;
  localparam logic [POS_TOL_W-1:0] POS_TOL_RESET = 23'd819;
  localparam logic [RATE_W-1:0]    RATE_RESET    = 13'd1229;

  // atan(2^-i) in Q20, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_q20(input logic [ATAN_IDX_W-1:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0:    r = 25'sd823550;
      5'd1:    r = 25'sd486170;
      5'd2:    r = 25'sd256879;
      5'd3:    r = 25'sd130396;
      5'd4:    r = 25'sd65451;
      5'd5:    r = 25'sd32757;
      5'd6:    r = 25'sd16383;
      5'd7:    r = 25'sd8192;
      5'd8:    r = 25'sd4096;
      5'd9:    r = 25'sd2048;
      5'd10:   r = 25'sd1024;
      5'd11:   r = 25'sd512;
      5'd12:   r = 25'sd256;
      5'd13:   r = 25'sd128;
      5'd14:   r = 25'sd64;
      5'd15:   r = 25'sd32;
      5'd16:   r = 25'sd16;
      5'd17:   r = 25'sd8;
      5'd18:   r = 25'sd4;
      5'd19:   r = 25'sd2;
      5'd20:   r = 25'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/ggh_if.sv =====
`timescale 1ns / 1ps

interface ggh_odom_if;
  import ggh_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [HDG_W-1:0]  heading;

  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface ggh_cmd_if;
  import ggh_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [LIN_W-1:0]            linear_cmd;
  logic signed [ANG_CMD_W-1:0] angular_cmd;
  logic [MODE_W-1:0]           mode;

  modport source (output valid, linear_cmd, angular_cmd, mode, input ready);
  modport sink (input valid, linear_cmd, angular_cmd, mode, output ready);
endinterface

// ===== hdl/go_to_goal_heading_controller.sv =====
`timescale 1ns / 1ps
// Go-to-goal heading controller.
// odom (sink): one odometry sample per transfer (pos_x, pos_y Q12, heading Q13).
// cmd (source): one command per sample (linear_cmd, angular_cmd Q12, mode).
// Configuration: cfg_write, cfg_index, cfg_data write goal, tolerances and speeds;
// write only while no sample is in flight.
// Each sample runs a vectoring CORDIC on one shared add/shift datapath, one
// micro-rotation per cycle, then squares the distances on one shared multiplier.
// From the odom transfer a sample passes the load, CORDIC, error, squaring, decide
// and output states before cmd valid (load goes straight to output once done mode
// is reached); CORDIC_ITERATIONS sets the number of micro-rotations. A new sample
// is taken only after the result is loaded, so none is accepted mid-computation.
// The result sits in an output register: while the receiver stalls, the next
// sample is still taken and processed, and it waits only to load its result.
// Synchronous reset returns to heading mode with a zero held command, restores
// the default registers and drops any pending result.
module go_to_goal_heading_controller #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ggh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ggh_pkg::CFG_DATA_W-1:0]   cfg_data,
  ggh_odom_if.sink                         odom,
  ggh_cmd_if.source                        cmd
);
  import ggh_pkg::*;

  localparam int ITER_W = $clog2(CORDIC_ITERATIONS);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERATIONS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_CORDIC, S_ERROR, S_SQ_X, S_SQ_Y, S_SQ_T, S_DECIDE, S_OUT
  } state_t;

  state_t state;

  logic signed [POS_W-1:0]     goal_x;
  logic signed [POS_W-1:0]     goal_y;
  logic [YAW_TOL_W-1:0]        yaw_tolerance;
  logic [POS_TOL_W-1:0]        position_tolerance;
  logic [RATE_W-1:0]           turn_rate;
  logic [RATE_W-1:0]           drive_speed;

  mode_t                       control_mode;
  logic [LIN_W-1:0]            held_linear;
  logic signed [ANG_CMD_W-1:0] held_angular;

  logic signed [POS_W-1:0]     px;
  logic signed [POS_W-1:0]     py;
  logic signed [HDG_W-1:0]     hd;
  logic signed [DIFF_W-1:0]    dx;
  logic signed [DIFF_W-1:0]    dy;
  logic signed [XY_W-1:0]      x;
  logic signed [XY_W-1:0]      y;
  logic signed [Z_W-1:0]       z;
  logic [ITER_W-1:0]           iter;
  logic                        on_goal;
  logic signed [ERR_W-1:0]     err;
  logic [D2_W-1:0]             d2;
  logic [SQ_W-1:0]             t2;

  logic                        out_valid;
  logic [LIN_W-1:0]            out_linear;
  logic signed [ANG_CMD_W-1:0] out_angular;
  logic [MODE_W-1:0]           out_mode;

  logic signed [DIFF_W-1:0]    dx_c;
  logic signed [DIFF_W-1:0]    dy_c;
  logic signed [XY_W-1:0]      x_pre;
  logic signed [XY_W-1:0]      y_pre;
  logic signed [XY_W-1:0]      x_sh;
  logic signed [XY_W-1:0]      y_sh;
  logic signed [Z_W-1:0]       atan_i;
  logic signed [Z_W-1:0]       z_round;
  logic signed [BRG_W-1:0]     bearing;
  logic signed [ERR_W-1:0]     err_raw;
  logic signed [ERR_W-1:0]     err_wrap;
  logic [ERR_W-1:0]            err_abs;
  logic                        off;
  logic signed [DIFF_W-1:0]    mul_a;
  logic signed [PROD_W-1:0]    mul_p;

  assign dx_c  = {goal_x[POS_W-1], goal_x} - {px[POS_W-1], px};
  assign dy_c  = {goal_y[POS_W-1], goal_y} - {py[POS_W-1], py};
  assign x_pre = {{(XY_W-DIFF_W-8){dx_c[DIFF_W-1]}}, dx_c, 8'b0};
  assign y_pre = {{(XY_W-DIFF_W-8){dy_c[DIFF_W-1]}}, dy_c, 8'b0};

  assign x_sh   = x >>> iter;
  assign y_sh   = y >>> iter;
  assign atan_i = atan_q20(ATAN_IDX_W'(iter));

  assign z_round = z + Z_ROUND;
  assign bearing = on_goal ? '0 : z_round[Z_W-1:7];
  assign err_raw = {{(ERR_W-BRG_W){bearing[BRG_W-1]}}, bearing}
                 - {{(ERR_W-HDG_W){hd[HDG_W-1]}}, hd};

  always_comb begin
    if (err_raw > ERR_PI) begin
      err_wrap = err_raw - ERR_TWO_PI;
    end else if (err_raw < ERR_NEG_PI) begin
      err_wrap = err_raw + ERR_TWO_PI;
    end else begin
      err_wrap = err_raw;
    end
  end

  assign err_abs = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign off     = err_abs > {{(ERR_W-YAW_TOL_W){1'b0}}, yaw_tolerance};

  always_comb begin
    case (state)
      S_SQ_Y:  mul_a = dy;
      S_SQ_T:  mul_a = {{(DIFF_W-POS_TOL_W){1'b0}}, position_tolerance};
      default: mul_a = dx;
    endcase
  end

  assign mul_p = mul_a * mul_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x             <= '0;
      goal_y             <= '0;
      yaw_tolerance      <= YAW_TOL_RESET;
      position_tolerance <= POS_TOL_RESET;
      turn_rate          <= RATE_RESET;
      drive_speed        <= RATE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GOAL_X:      goal_x             <= cfg_data;
        CFG_GOAL_Y:      goal_y             <= cfg_data;
        CFG_YAW_TOL:     yaw_tolerance      <= cfg_data[YAW_TOL_W-1:0];
        CFG_POS_TOL:     position_tolerance <= cfg_data[POS_TOL_W-1:0];
        CFG_TURN_RATE:   turn_rate          <= cfg_data[RATE_W-1:0];
        CFG_DRIVE_SPEED: drive_speed        <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      control_mode <= MODE_HEADING;
      held_linear  <= '0;
      held_angular <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && cmd.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (odom.valid) begin
            px    <= odom.pos_x;
            py    <= odom.pos_y;
            hd    <= odom.heading;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          dx      <= dx_c;
          dy      <= dy_c;
          on_goal <= (dx_c == '0) && (dy_c == '0);
          iter    <= '0;
          if (dx_c[DIFF_W-1]) begin
            x <= -x_pre;
            y <= -y_pre;
            z <= dy_c[DIFF_W-1] ? -Q20_PI : Q20_PI;
          end else begin
            x <= x_pre;
            y <= y_pre;
            z <= '0;
          end
          if (control_mode == MODE_DONE) begin
            held_linear  <= '0;
            held_angular <= '0;
            state        <= S_OUT;
          end else begin
            state <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (!y[XY_W-1]) begin
            x <= x + y_sh;
            y <= y - x_sh;
            z <= z + atan_i;
          end else begin
            x <= x - y_sh;
            y <= y + x_sh;
            z <= z - atan_i;
          end
          iter <= iter + 1'b1;
          if (iter == ITER_LAST) begin
            state <= S_ERROR;
          end
        end
        S_ERROR: begin
          err   <= err_wrap;
          state <= S_SQ_X;
        end
        S_SQ_X: begin
          d2    <= {1'b0, mul_p[SQ_W-1:0]};
          state <= S_SQ_Y;
        end
        S_SQ_Y: begin
          d2    <= d2 + {1'b0, mul_p[SQ_W-1:0]};
          state <= S_SQ_T;
        end
        S_SQ_T: begin
          t2    <= mul_p[SQ_W-1:0];
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (control_mode == MODE_HEADING) begin
            held_linear <= '0;
            if (off) begin
              held_angular <= (err > 0) ? -$signed({1'b0, turn_rate})
                                        : $signed({1'b0, turn_rate});
            end else begin
              held_angular <= '0;
              control_mode <= MODE_STRAIGHT;
            end
          end else begin
            if (d2 > {1'b0, t2}) begin
              held_linear  <= drive_speed;
              held_angular <= '0;
              if (off) begin
                control_mode <= MODE_HEADING;
              end
            end else begin
              control_mode <= off ? MODE_HEADING : MODE_DONE;
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || cmd.ready) begin
            out_valid   <= 1'b1;
            out_linear  <= held_linear;
            out_angular <= held_angular;
            out_mode    <= control_mode;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign odom.ready      = (state == S_IDLE);
  assign cmd.valid       = out_valid;
  assign cmd.linear_cmd  = out_linear;
  assign cmd.angular_cmd = out_angular;
  assign cmd.mode        = out_mode;

`include "go_to_goal_heading_controller_defines.svh"

  `GGH_ASSERT_NEXT(a_busy_after_transfer, odom.valid && odom.ready, !odom.ready, "sample taken while busy")
  `GGH_ASSERT_NEXT(a_done_sticky, control_mode == MODE_DONE, control_mode == MODE_DONE, "left done mode")
  `GGH_ASSERT_IMPL(a_straight_no_turn, cmd.valid && cmd.mode == MODE_STRAIGHT, cmd.angular_cmd == 0, "turn in straight mode")

endmodule

// ===== sim/tb_go_to_goal_heading_controller.sv =====
`timescale 1ns / 1ps

module tb_go_to_goal_heading_controller;
  import ggh_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam longint ANG_PI_Q13 = 25736;
  localparam longint ANG_TWO_PI_Q13 = 51472;
  localparam longint PI_Q20 = 3294199;
  localparam longint POS_MAX = 8388607;
  localparam longint POS_MIN = -8388608;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [HDG_W-1:0] heading;
  } odom_sample_t;

  typedef struct packed {
    logic [LIN_W-1:0]            linear;
    logic signed [ANG_CMD_W-1:0] angular;
    mode_t                       mode;
  } drive_cmd_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ggh_odom_if odom ();
  ggh_cmd_if cmd ();

  go_to_goal_heading_controller #(
    .CORDIC_ITERATIONS(CORDIC_STEPS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .odom(odom),
    .cmd(cmd)
  );

  always #1 clk = ~clk;

  longint atan_steps [16] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                              4096, 2048, 1024, 512, 256, 128, 64, 32};

  logic signed [POS_W-1:0] goal_x, goal_y;
  logic [YAW_TOL_W-1:0] yaw_tol;
  logic [POS_TOL_W-1:0] pos_tol;
  logic [RATE_W-1:0] turn_rate, drive_speed;
  drive_cmd_t held;

  drive_cmd_t expected_cmds [$];
  int failures = 0;
  int samples = 0;
  int writes = 0;
  int settings = 0;
  int mode_hits [0:3] = '{0, 0, 0, 0};
  int stalled_cycles = 0;
  bit steady = 1'b0;

  function automatic longint bearing_of(input longint dx, input longint dy);
    longint x, y, z, xs, ys;
    if (dx == 0 && dy == 0) return 0;
    x = dx * 256;
    y = dy * 256;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_Q20 : -PI_Q20;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = y >>> i;
      ys = x >>> i;
      if (y >= 0) begin
        x += xs;
        y -= ys;
        z += atan_steps[i];
      end else begin
        x -= xs;
        y += ys;
        z -= atan_steps[i];
      end
    end
    return (z + 64) >>> 7;
  endfunction

  function automatic drive_cmd_t step_controller(input drive_cmd_t cur, input odom_sample_t s);
    drive_cmd_t nxt;
    longint dx, dy, err, d2, t2;
    bit off;
    nxt = cur;
    dx = longint'(goal_x) - longint'($signed(s.pos_x));
    dy = longint'(goal_y) - longint'($signed(s.pos_y));
    if (cur.mode == MODE_DONE) begin
      nxt.linear = '0;
      nxt.angular = '0;
    end else begin
      err = bearing_of(dx, dy) - longint'($signed(s.heading));
      if (err > ANG_PI_Q13) err -= ANG_TWO_PI_Q13;
      else if (err < -ANG_PI_Q13) err += ANG_TWO_PI_Q13;
      off = ((err < 0) ? -err : err) > longint'(yaw_tol);
      if (cur.mode == MODE_HEADING) begin
        nxt.linear = '0;
        if (!off) begin
          nxt.angular = '0;
          nxt.mode = MODE_STRAIGHT;
        end else if (err > 0) begin
          nxt.angular = -$signed({1'b0, turn_rate});
        end else begin
          nxt.angular = $signed({1'b0, turn_rate});
        end
      end else begin
        d2 = dx * dx + dy * dy;
        t2 = longint'(pos_tol) * longint'(pos_tol);
        if (d2 > t2) begin
          nxt.linear = drive_speed;
          nxt.angular = '0;
        end else begin
          nxt.mode = MODE_DONE;
        end
        if (off) nxt.mode = MODE_HEADING;
      end
    end
    return nxt;
  endfunction

  function automatic logic signed [HDG_W-1:0] aim_at(input longint px, input longint py,
                                                     input longint offset);
    return HDG_W'(bearing_of(longint'(goal_x) - px, longint'(goal_y) - py) + offset);
  endfunction

  function automatic longint clamp_pos(input longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic odom_sample_t make_sample(input bit aligned, input bit turn_away);
    odom_sample_t s;
    longint span, aim;
    if ($urandom_range(0, 99) < 45) begin
      span = ($urandom_range(0, 3) == 0) ? 16 : longint'(pos_tol) * 2 + 64;
      s.pos_x = POS_W'(clamp_pos(longint'(goal_x) + longint'($urandom_range(0, 2 * span)) - span));
      s.pos_y = POS_W'(clamp_pos(longint'(goal_y) + longint'($urandom_range(0, 2 * span)) - span));
    end else begin
      s.pos_x = POS_W'($urandom);
      s.pos_y = POS_W'($urandom);
    end
    aim = bearing_of(longint'(goal_x) - longint'($signed(s.pos_x)),
                     longint'(goal_y) - longint'($signed(s.pos_y)));
    if (turn_away) begin
      s.heading = HDG_W'(aim + ANG_PI_Q13);
    end else if (aligned) begin
      aim += longint'($urandom_range(0, 2 * yaw_tol + 6)) - longint'(yaw_tol) - 3;
      if ($urandom_range(0, 9) == 0)
        aim += $urandom_range(0, 1) ? ANG_TWO_PI_Q13 : -ANG_TWO_PI_Q13;
      s.heading = HDG_W'(aim);
    end else begin
      s.heading = HDG_W'($urandom);
    end
    return s;
  endfunction

  task automatic push_sample(input odom_sample_t s);
    drive_cmd_t nxt;
    if (!steady && $urandom_range(0, 99) < 17) begin
      odom.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    odom.valid <= 1'b1;
    odom.pos_x <= s.pos_x;
    odom.pos_y <= s.pos_y;
    odom.heading <= s.heading;
    @(posedge clk);
    while (!odom.ready) @(posedge clk);
    nxt = step_controller(held, s);
    held = nxt;
    expected_cmds.insert(expected_cmds.size(), nxt);
    samples++;
  endtask

  task automatic send_at(input longint px, input longint py, input longint hd);
    odom_sample_t s;
    s.pos_x = POS_W'(px);
    s.pos_y = POS_W'(py);
    s.heading = HDG_W'(hd);
    push_sample(s);
  endtask

  // keep away from the goal unless asked: done mode only clears on reset
  task automatic send_sample(input bit aligned, input bit allow_done);
    odom_sample_t s;
    drive_cmd_t nxt;
    s = make_sample(aligned, 1'b0);
    for (int tries = 1; tries < 40 && !allow_done; tries++) begin
      nxt = step_controller(held, s);
      if (nxt.mode != MODE_DONE) break;
      s = make_sample(aligned, tries >= 20);
    end
    push_sample(s);
  endtask

  task automatic wait_idle();
    odom.valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    writes++;
  endtask

  task automatic configure(input logic [POS_W-1:0] gx, input logic [POS_W-1:0] gy,
                           input logic [YAW_TOL_W-1:0] yt, input logic [POS_TOL_W-1:0] pt,
                           input logic [RATE_W-1:0] tr, input logic [RATE_W-1:0] ds);
    wait_idle();
    write_reg(CFG_GOAL_X, gx);
    write_reg(CFG_GOAL_Y, gy);
    write_reg(CFG_YAW_TOL, CFG_DATA_W'(yt));
    write_reg(CFG_POS_TOL, CFG_DATA_W'(pt));
    write_reg(CFG_TURN_RATE, CFG_DATA_W'(tr));
    write_reg(CFG_DRIVE_SPEED, CFG_DATA_W'(ds));
    cfg_write <= 1'b0;
    goal_x = gx;
    goal_y = gy;
    yaw_tol = yt;
    pos_tol = pt;
    turn_rate = tr;
    drive_speed = ds;
    settings++;
  endtask

  task automatic test_reset_defaults();
    send_at(0, 0, 0);
    send_at(0, 0, 10000);
    send_at(POS_MIN, 0, 0);
    send_at(POS_MIN, 0, 0);
    send_at(POS_MIN, 0, 400);
    send_at(POS_MAX, POS_MAX, 0);
    send_at(POS_MAX, POS_MIN, 32767);
    send_at(0, -4096, -32768);
    send_at(0, 4096, 32767);
    send_at(4096, 0, 25736);
  endtask

  task automatic test_limits();
    configure(POS_W'(POS_MAX), POS_W'(POS_MIN), '0, '0, {RATE_W{1'b1}}, {RATE_W{1'b1}});
    send_at(POS_MIN, POS_MAX, aim_at(POS_MIN, POS_MAX, 0));
    send_at(POS_MIN, POS_MAX, aim_at(POS_MIN, POS_MAX, 0));
    send_at(POS_MIN, POS_MAX, aim_at(POS_MIN, POS_MAX, 1));
    send_at(POS_MIN, POS_MAX, aim_at(POS_MIN, POS_MAX, -1));
    send_at(POS_MAX, POS_MIN, 0);
    send_at(POS_MAX, POS_MIN + 1, aim_at(POS_MAX, POS_MIN + 1, 0));
    send_at(POS_MIN, POS_MIN, -32768);
  endtask

  task automatic test_wide_tolerance();
    configure('0, '0, YAW_TOL_W'(25736), '0, '0, '0);
    send_at(0, POS_MAX, -32768);
    send_at(POS_MAX, 0, 32767);
    send_at(-1, -1, 0);
    send_at(100, -100, 25736);
    send_at(-4096, 4096, -25736);
  endtask

  task automatic test_setting_sweep();
    configure(POS_W'(POS_MIN), POS_W'(POS_MAX), '0, '0, '0, {RATE_W{1'b1}});
    repeat (40) send_sample($urandom_range(0, 99) < 65, 1'b0);
    configure(POS_W'(POS_MAX), POS_W'(POS_MIN), YAW_TOL_W'(25736), POS_TOL_W'(4096),
              {RATE_W{1'b1}}, '0);
    repeat (40) send_sample($urandom_range(0, 99) < 65, 1'b0);
    configure('0, '0, YAW_TOL_RESET, POS_TOL_RESET, RATE_RESET, RATE_RESET);
    repeat (40) send_sample($urandom_range(0, 99) < 65, 1'b0);
  endtask

  task automatic test_random_goals();
    for (int phase = 0; phase < 6; phase++) begin
      configure($urandom_range(0, 1) ? POS_W'($urandom) : POS_W'($urandom_range(0, 65535) - 32768),
                $urandom_range(0, 1) ? POS_W'($urandom) : POS_W'($urandom_range(0, 65535) - 32768),
                YAW_TOL_W'($urandom_range(0, 1) ? $urandom_range(0, 600) : $urandom_range(0, 25736)),
                POS_TOL_W'($urandom_range(0, 1) ? $urandom_range(0, 4096) : $urandom_range(0, 1 << 20)),
                RATE_W'($urandom_range(0, 8191)), RATE_W'($urandom_range(0, 8191)));
      steady = (phase == 2);
      repeat (100) send_sample($urandom_range(0, 99) < 65, 1'b0);
    end
    steady = 1'b0;
  endtask

  task automatic test_goal_reached();
    configure(POS_W'($urandom), POS_W'($urandom), YAW_TOL_RESET, {POS_TOL_W{1'b1}},
              RATE_W'($urandom_range(1, 8191)), RATE_W'($urandom_range(1, 8191)));
    for (int n = 0; n < 12 && held.mode != MODE_DONE; n++) send_sample(1'b1, 1'b1);
    repeat (6) send_sample(1'b0, 1'b1);
  endtask

  always @(posedge clk) begin
    cmd.ready <= steady || ($urandom_range(0, 99) >= 17);
  end

  always @(posedge clk) begin
    drive_cmd_t want;
    if (!rst && cmd.valid && cmd.ready) begin
      if (expected_cmds.size() == 0) begin
        $error("unexpected command transfer: linear_cmd %0d angular_cmd %0d mode %0d",
               cmd.linear_cmd, $signed(cmd.angular_cmd), cmd.mode);
        failures++;
      end else begin
        want = expected_cmds.pop_front();
        mode_hits[want.mode]++;
        if (cmd.linear_cmd !== want.linear) begin
          $error("linear_cmd expected %0d actual %0d", want.linear, cmd.linear_cmd);
          failures++;
        end
        if (cmd.angular_cmd !== want.angular) begin
          $error("angular_cmd expected %0d actual %0d", $signed(want.angular),
                 $signed(cmd.angular_cmd));
          failures++;
        end
        if (cmd.mode !== want.mode) begin
          $error("mode expected %0d actual %0d", want.mode, cmd.mode);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (odom.valid && odom.ready) || (cmd.valid && cmd.ready)) stalled_cycles <= 0;
    else stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles == WATCHDOG_LIMIT) begin
      $error("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    odom.valid <= 1'b0;
    odom.pos_x <= '0;
    odom.pos_y <= '0;
    odom.heading <= '0;
    goal_x = '0;
    goal_y = '0;
    yaw_tol = YAW_TOL_RESET;
    pos_tol = POS_TOL_RESET;
    turn_rate = RATE_RESET;
    drive_speed = RATE_RESET;
    held = '{linear: '0, angular: '0, mode: MODE_HEADING};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_limits();
    test_wide_tolerance();
    test_setting_sweep();
    test_random_goals();
    test_goal_reached();
    wait_idle();
    repeat (30) @(posedge clk);
    $display("Sent %0d odometry samples under %0d register settings (%0d register writes).",
             samples, settings, writes);
    $display("Commands checked in heading mode %0d, straight mode %0d, done mode %0d.",
             mode_hits[MODE_HEADING], mode_hits[MODE_STRAIGHT], mode_hits[MODE_DONE]);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== go_to_goal_heading_controller.f =====
+incdir+hdl
hdl/ggh_pkg.sv
hdl/ggh_if.sv
hdl/go_to_goal_heading_controller.sv
sim/tb_go_to_goal_heading_controller.sv
